/* hdl/qrc_pkg.sv */
// ----------------------------------------------------------------------------
// qrc_pkg: shared types, widths and helpers for the quad regularity checker
// Holds the beat structs, derived widths and the square-root step function.
// ----------------------------------------------------------------------------
package qrc_pkg;

    localparam int COORD_BITS       = 12;
    localparam int RADIUS_FRAC_BITS = 4;

    // centroid sums and quarter-pixel offsets
    localparam int SUM_BITS      = COORD_BITS + 2;
    localparam int SQ_BITS       = 2 * SUM_BITS;
    localparam int S_BITS        = SQ_BITS + 1;
    localparam int RAD_RAW_BITS  = S_BITS + 2 * RADIUS_FRAC_BITS;
    localparam int ROOT_BITS     = (RAD_RAW_BITS + 1) / 2;
    localparam int RADICAND_BITS = 2 * ROOT_BITS;
    localparam int REM_BITS      = ROOT_BITS + 2;
    localparam int R_BITS        = ROOT_BITS - 2;
    localparam int SUMR_BITS     = R_BITS + 2;
    localparam int MR_BITS       = COORD_BITS + RADIUS_FRAC_BITS + 2;
    localparam int TOL_BITS      = 8;
    localparam int PROD_BITS     = SUMR_BITS + TOL_BITS + 1;
    localparam int ADDR_BITS     = 3;

    // register indexes, taken from paddr[2]
    localparam logic REG_TOLERANCE  = 1'b0;
    localparam logic REG_MIN_RADIUS = 1'b1;

    localparam logic [TOL_BITS-1:0]   TOLERANCE_RESET  = TOL_BITS'(38);
    localparam logic [COORD_BITS-1:0] MIN_RADIUS_RESET = COORD_BITS'(33);

    typedef struct packed {
        logic [COORD_BITS-1:0] corner0_x;
        logic [COORD_BITS-1:0] corner0_y;
        logic [COORD_BITS-1:0] corner1_x;
        logic [COORD_BITS-1:0] corner1_y;
        logic [COORD_BITS-1:0] corner2_x;
        logic [COORD_BITS-1:0] corner2_y;
        logic [COORD_BITS-1:0] corner3_x;
        logic [COORD_BITS-1:0] corner3_y;
    } corners_t;

    typedef struct packed {
        logic                  is_regular;
        logic [COORD_BITS-1:0] box_min_x;
        logic [COORD_BITS-1:0] box_min_y;
        logic [COORD_BITS-1:0] box_max_x;
        logic [COORD_BITS-1:0] box_max_y;
    } result_t;

    typedef struct packed {
        logic [REM_BITS-1:0]  rem;
        logic [ROOT_BITS-1:0] q;
    } sqrt_step_t;

    // one digit of the restoring square root: bring down two bits, try q*4+1
    function automatic sqrt_step_t sqrt_step(input logic [REM_BITS-1:0] rem,
                                             input logic [ROOT_BITS-1:0] q,
                                             input logic [1:0] pair);
        logic [REM_BITS-1:0] rem_sh;
        logic [REM_BITS-1:0] trial;
        sqrt_step_t          res;
        rem_sh = {rem[REM_BITS-3:0], pair};
        trial  = {q, 2'b01};
        if (rem_sh >= trial)
        begin
            res.rem = rem_sh - trial;
            res.q   = {q[ROOT_BITS-2:0], 1'b1};
        end
        else
        begin
            res.rem = rem_sh;
            res.q   = {q[ROOT_BITS-2:0], 1'b0};
        end
        return res;
    endfunction

endpackage

/* hdl/quad_regularity_check_bbox.sv */
// ----------------------------------------------------------------------------
// quad_regularity_check_bbox: quadrilateral regularity test and bounding box
// Centroid offsets, radii by pipelined square root, cross-multiplied ratio
// test against the mean, a minimum mean radius check, and the axis-aligned
// box of the four corners.
// Pipeline: 4 front stages, 19 square-root stages, one per root bit, then sum,
//   multiply, compare; the done strobe marks the result of each start beat.
// Throughput: one beat per cycle; busy is always low.
// Reset: rst_n clears all valid bits and loads tolerance = 38, min_radius = 33.
// The receiver cannot stall: each result shows for exactly one cycle.
// ----------------------------------------------------------------------------
module quad_regularity_check_bbox (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  qrc_pkg::corners_t                 corners,
    output logic                              done,
    output qrc_pkg::result_t                  result,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [qrc_pkg::ADDR_BITS-1:0]     paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);
    import qrc_pkg::*;

    // stage indexes along the valid line
    localparam int ROOT_STAGE = 3 + ROOT_BITS;
    localparam int SUM_STAGE  = ROOT_STAGE + 1;
    localparam int PROD_STAGE = SUM_STAGE + 1;
    localparam int NSTAGE     = PROD_STAGE + 2;

    typedef struct packed {
        logic [COORD_BITS-1:0] min_x;
        logic [COORD_BITS-1:0] min_y;
        logic [COORD_BITS-1:0] max_x;
        logic [COORD_BITS-1:0] max_y;
    } box_t;

    // ---------------- configuration port ----------------
    logic [TOL_BITS-1:0]   tolerance_reg;
    logic [COORD_BITS-1:0] min_radius_reg;
    logic                  cfg_write;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tolerance_reg  <= TOLERANCE_RESET;
            min_radius_reg <= MIN_RADIUS_RESET;
        end
        else if (cfg_write)
        begin
            unique case (paddr[2])
                REG_TOLERANCE:  tolerance_reg  <= pwdata[TOL_BITS-1:0];
                REG_MIN_RADIUS: min_radius_reg <= pwdata[COORD_BITS-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[2])
            REG_TOLERANCE:  prdata = 32'(tolerance_reg);
            REG_MIN_RADIUS: prdata = 32'(min_radius_reg);
            default:        prdata = 32'd0;
        endcase
    end

    // ---------------- valid line ----------------
    // The pipeline never stalls, so advance every stage each cycle.
    logic [NSTAGE-1:0] vld_reg;

    assign busy = 1'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
            vld_reg <= {vld_reg[NSTAGE-2:0], start};
    end

    // ---------------- stage 0: capture beat ----------------
    corners_t in_reg;

    always_ff @(posedge clk)
    begin
        in_reg <= corners;
    end

    logic [COORD_BITS-1:0] cx[4];
    logic [COORD_BITS-1:0] cy[4];

    assign cx[0] = in_reg.corner0_x;
    assign cy[0] = in_reg.corner0_y;
    assign cx[1] = in_reg.corner1_x;
    assign cy[1] = in_reg.corner1_y;
    assign cx[2] = in_reg.corner2_x;
    assign cy[2] = in_reg.corner2_y;
    assign cx[3] = in_reg.corner3_x;
    assign cy[3] = in_reg.corner3_y;

    // ---------------- stage 1: offsets and box ----------------
    logic [SUM_BITS-1:0] sx;
    logic [SUM_BITS-1:0] sy;
    logic [SUM_BITS-1:0] dx_next[4];
    logic [SUM_BITS-1:0] dy_next[4];
    logic [SUM_BITS-1:0] dx_reg [4];
    logic [SUM_BITS-1:0] dy_reg [4];
    box_t                box_next;
    box_t                box_reg[1:PROD_STAGE];

    always_comb
    begin
        logic [SUM_BITS-1:0] qx;
        logic [SUM_BITS-1:0] qy;
        sx = SUM_BITS'(cx[0]) + SUM_BITS'(cx[1]) + SUM_BITS'(cx[2]) + SUM_BITS'(cx[3]);
        sy = SUM_BITS'(cy[0]) + SUM_BITS'(cy[1]) + SUM_BITS'(cy[2]) + SUM_BITS'(cy[3]);
        box_next.min_x = cx[0];
        box_next.max_x = cx[0];
        box_next.min_y = cy[0];
        box_next.max_y = cy[0];
        for (int k = 0; k < 4; k++)
        begin
            // quarter-pixel offset from the centroid, as a magnitude
            qx = {cx[k], 2'b00};
            qy = {cy[k], 2'b00};
            dx_next[k] = (qx >= sx) ? qx - sx : sx - qx;
            dy_next[k] = (qy >= sy) ? qy - sy : sy - qy;
            if (k > 0)
            begin
                if (cx[k] < box_next.min_x) box_next.min_x = cx[k];
                if (cx[k] > box_next.max_x) box_next.max_x = cx[k];
                if (cy[k] < box_next.min_y) box_next.min_y = cy[k];
                if (cy[k] > box_next.max_y) box_next.max_y = cy[k];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg     <= dx_next;
        dy_reg     <= dy_next;
        box_reg[1] <= box_next;
        for (int s = 2; s <= PROD_STAGE; s++)
            box_reg[s] <= box_reg[s-1];
    end

    // ---------------- stage 2: squares ----------------
    logic [SQ_BITS-1:0] sqx_reg[4];
    logic [SQ_BITS-1:0] sqy_reg[4];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            sqx_reg[k] <= SQ_BITS'(dx_reg[k]) * SQ_BITS'(dx_reg[k]);
            sqy_reg[k] <= SQ_BITS'(dy_reg[k]) * SQ_BITS'(dy_reg[k]);
        end
    end

    // ---------------- stage 3: radicand ----------------
    logic [RADICAND_BITS-1:0] rad_reg[4];

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            rad_reg[k] <= RADICAND_BITS'(S_BITS'(sqx_reg[k]) + S_BITS'(sqy_reg[k]))
                          << (2 * RADIUS_FRAC_BITS);
        end
    end

    // ---------------- square-root lanes ----------------
    logic [ROOT_BITS-1:0] root[4];

    for (genvar k = 0; k < 4; k++)
    begin : g_lane
        qrc_sqrt_pipe u_sqrt (
            .clk      (clk),
            .radicand (rad_reg[k]),
            .root     (root[k])
        );
    end

    // ---------------- sum of radii ----------------
    logic [R_BITS-1:0]    r_reg [4];
    logic [SUMR_BITS-1:0] sumr_reg;

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
            r_reg[k] <= R_BITS'(root[k] >> 2);
        sumr_reg <= SUMR_BITS'(root[0] >> 2) + SUMR_BITS'(root[1] >> 2)
                  + SUMR_BITS'(root[2] >> 2) + SUMR_BITS'(root[3] >> 2);
    end

    // ---------------- tolerance bounds ----------------
    logic [R_BITS-1:0]    r2_reg[4];
    logic [PROD_BITS-1:0] hi_reg;
    logic [PROD_BITS-1:0] lo_reg;
    logic                 mean_ok_reg;

    always_ff @(posedge clk)
    begin
        r2_reg      <= r_reg;
        hi_reg      <= PROD_BITS'(sumr_reg) * PROD_BITS'(9'd256 + 9'(tolerance_reg));
        lo_reg      <= PROD_BITS'(sumr_reg) * PROD_BITS'(9'd256 - 9'(tolerance_reg));
        mean_ok_reg <= (MR_BITS + 1)'(sumr_reg)
                       > ((MR_BITS + 1)'(min_radius_reg) << (RADIUS_FRAC_BITS + 2));
    end

    // ---------------- compare and drive result ----------------
    logic    pass_next;
    result_t result_reg;

    always_comb
    begin
        logic [PROD_BITS-1:0] lhs;
        pass_next = mean_ok_reg;
        for (int k = 0; k < 4; k++)
        begin
            lhs = PROD_BITS'(r2_reg[k]) << 10;
            if (lhs > hi_reg || lhs < lo_reg)
                pass_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg.is_regular <= pass_next;
        result_reg.box_min_x  <= box_reg[PROD_STAGE].min_x;
        result_reg.box_min_y  <= box_reg[PROD_STAGE].min_y;
        result_reg.box_max_x  <= box_reg[PROD_STAGE].max_x;
        result_reg.box_max_y  <= box_reg[PROD_STAGE].max_y;
    end

    assign done   = vld_reg[NSTAGE-1];
    assign result = result_reg;

endmodule

/* hdl/qrc_sqrt_pipe.sv */
// ----------------------------------------------------------------------------
// qrc_sqrt_pipe: pipelined integer square root
// One root bit per stage; a new radicand may enter every cycle.
// ----------------------------------------------------------------------------
module qrc_sqrt_pipe (
    input  logic                                clk,
    input  logic [qrc_pkg::RADICAND_BITS-1:0]   radicand,
    output logic [qrc_pkg::ROOT_BITS-1:0]       root
);
    import qrc_pkg::*;

    logic [REM_BITS-1:0]      rem_reg  [ROOT_BITS];
    logic [ROOT_BITS-1:0]     q_reg    [ROOT_BITS];
    logic [RADICAND_BITS-1:0] rad_reg  [ROOT_BITS];
    sqrt_step_t               step_next[ROOT_BITS];

    always_comb
    begin
        step_next[0] = sqrt_step(REM_BITS'(0), ROOT_BITS'(0),
                                 radicand[RADICAND_BITS-1 -: 2]);
        for (int s = 1; s < ROOT_BITS; s++)
        begin
            step_next[s] = sqrt_step(rem_reg[s-1], q_reg[s-1],
                                     rad_reg[s-1][RADICAND_BITS-1 -: 2]);
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg[0] <= step_next[0].rem;
        q_reg[0]   <= step_next[0].q;
        rad_reg[0] <= radicand << 2;
        for (int s = 1; s < ROOT_BITS; s++)
        begin
            rem_reg[s] <= step_next[s].rem;
            q_reg[s]   <= step_next[s].q;
            rad_reg[s] <= rad_reg[s-1] << 2;
        end
    end

    assign root = q_reg[ROOT_BITS-1];

endmodule
